// ===== hdl/frd_pkg.sv =====
package frd_pkg;

	localparam int TAG_W      = 32;
	localparam int TS_W       = 63;
	localparam int SLOT_W     = 64;
	localparam int IV_W       = 32;
	localparam int NUM_W      = IV_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int unsigned MAX_REPEATS_DEF = 16;

	localparam int SNAP_DIV = 100;
	localparam int SNAP_RND = 50;

	localparam logic [IV_W-1:0]  IV_RESET   = IV_W'(33333333);
	localparam logic [NUM_W-1:0] SNAP_RESET = NUM_W'((33333333 + SNAP_RND) / SNAP_DIV);

	localparam logic [CFG_IDX_W-1:0] REG_RUN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

	typedef enum logic [1:0] {
		ACT_FWD    = 2'd0,
		ACT_REPEAT = 2'd1,
		ACT_SKIP   = 2'd2,
		ACT_STOP   = 2'd3
	} action_t;

	typedef enum logic {
		S_IDLE,
		S_DEC
	} state_t;

	typedef struct packed {
		logic    cap;
		logic    emit;
		action_t act;
	} cmd_t;

	typedef struct packed {
		logic run;
		logic rep_go;
		logic skip_go;
		logic out_free;
		logic div_busy;
	} sts_t;

endpackage

// ===== hdl/frd_if.sv =====
interface frd_in_if;
	logic                         valid;
	logic                         ready;
	logic [frd_pkg::TAG_W-1:0]    frame_tag;
	logic [frd_pkg::TS_W-1:0]     frame_timestamp;

	modport source (output valid, output frame_tag, output frame_timestamp, input ready);
	modport sink (input valid, input frame_tag, input frame_timestamp, output ready);
endinterface

interface frd_out_if;
	logic                         valid;
	logic                         ready;
	logic [frd_pkg::TAG_W-1:0]    out_tag;
	logic [frd_pkg::TS_W-1:0]     out_timestamp;
	frd_pkg::action_t             action;
	logic                         last;

	modport source (output valid, output out_tag, output out_timestamp, output action,
		output last, input ready);
	modport sink (input valid, input out_tag, input out_timestamp, input action,
		input last, output ready);
endinterface

// ===== hdl/frd_div.sv =====
module frd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [frd_pkg::NUM_W-1:0] num,
	output logic                      busy,
	output logic [frd_pkg::NUM_W-1:0] quo
);

	localparam int NUM_W = frd_pkg::NUM_W;
	localparam int Y_W   = NUM_W - 2;
	localparam int R_W   = 32;
	localparam int P_W   = Y_W + R_W;
	localparam int SHIFT = 36;
	localparam logic [R_W-1:0] RECIP = 32'd2748779070;

	logic [Y_W-1:0] y_q;
	logic           pend_q;
	logic [NUM_W-1:0] quo_q;
	logic [P_W-1:0] prod;

	// divide by 100: shift by 2, then reciprocal multiply for 25
	assign prod = P_W'(y_q) * P_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			quo_q  <= frd_pkg::SNAP_RESET;
		end else if (start) begin
			pend_q <= 1'b1;
		end else if (pend_q) begin
			pend_q <= 1'b0;
			quo_q  <= NUM_W'(prod[P_W-1:SHIFT]);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q <= num[NUM_W-1:2];
		end
	end

	assign busy = pend_q;
	assign quo  = quo_q;

endmodule

// ===== hdl/frd_dp.sv =====
module frd_dp #(
	parameter int unsigned MAX_REPEATS = frd_pkg::MAX_REPEATS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [frd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [frd_pkg::TAG_W-1:0]      in_tag,
	input  logic [frd_pkg::TS_W-1:0]       in_ts,
	input  frd_pkg::cmd_t                  cmd,
	output frd_pkg::sts_t                  sts,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [frd_pkg::TAG_W-1:0]      out_tag,
	output logic [frd_pkg::TS_W-1:0]       out_ts,
	output frd_pkg::action_t               out_action,
	output logic                           out_last
);

	localparam int CNT_W  = $clog2(MAX_REPEATS + 1);
	localparam int SLOT_W = frd_pkg::SLOT_W;
	localparam int IV_W   = frd_pkg::IV_W;
	localparam int NUM_W  = frd_pkg::NUM_W;

	logic                      run_q;
	logic                      repeat_q;
	logic [IV_W-1:0]           iv_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [SLOT_W-1:0]         prev_q;
	logic                      has_rate_q;
	logic [CNT_W-1:0]          n_q;
	logic [frd_pkg::TAG_W-1:0] tag_q;
	logic [frd_pkg::TS_W-1:0]  ts_q;
	logic                      ov_q;

	logic [IV_W-1:0]   iv_eff;
	logic [IV_W-1:0]   wdata_eff;
	logic [IV_W-1:0]   half;
	logic [NUM_W-1:0]  snap;
	logic [NUM_W-1:0]  div_num;
	logic              div_start;
	logic              div_busy;
	logic [SLOT_W-1:0] ts64;
	logic [SLOT_W-1:0] in_ts64;
	logic [SLOT_W:0]   d_late;
	logic [SLOT_W:0]   d_early;
	logic              late;
	logic              early_skip;
	logic              snap_hit;
	logic [SLOT_W-1:0] add_base;
	logic [SLOT_W:0]   add_sum;
	logic [SLOT_W-1:0] slot_adv;
	logic              out_free;
	logic              run_toggle;

	assign iv_eff    = (iv_q == '0) ? IV_W'(1) : iv_q;
	assign wdata_eff = (cfg_wdata[IV_W-1:0] == '0) ? IV_W'(1) : cfg_wdata[IV_W-1:0];
	assign half      = IV_W'(({1'b0, iv_eff} + NUM_W'(1)) >> 1);

	assign div_start = cfg_we && (cfg_index == frd_pkg::REG_INTERVAL);
	assign div_num   = {1'b0, wdata_eff} + NUM_W'(frd_pkg::SNAP_RND);

	frd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.busy   (div_busy),
		.quo    (snap)
	);

	assign ts64    = {1'b0, ts_q};
	assign in_ts64 = {1'b0, in_ts};

	assign d_late     = {1'b0, ts64} - {1'b0, slot_q};
	assign d_early    = {1'b0, slot_q} - {1'b0, ts64};
	assign late       = !d_late[SLOT_W] && (d_late[SLOT_W-1:0] >= SLOT_W'(half));
	assign early_skip = !d_early[SLOT_W] && (d_early[SLOT_W-1:0] >= SLOT_W'(half));
	assign snap_hit   = !d_early[SLOT_W] && (d_early[SLOT_W-1:0] != '0) &&
		(d_early[SLOT_W-1:0] < SLOT_W'(snap));

	// slot advance, saturating
	assign add_base = ((cmd.act == frd_pkg::ACT_FWD) && snap_hit) ? ts64 : slot_q;
	assign add_sum  = {1'b0, add_base} + (SLOT_W+1)'(iv_eff);
	assign slot_adv = add_sum[SLOT_W] ? '1 : add_sum[SLOT_W-1:0];

	assign out_free   = !ov_q || out_ready;
	assign run_toggle = cfg_we && (cfg_index == frd_pkg::REG_RUN) && (cfg_wdata[0] != run_q);

	assign sts.run      = run_q;
	assign sts.rep_go   = repeat_q && (n_q < CNT_W'(MAX_REPEATS)) && has_rate_q && late;
	assign sts.skip_go  = !repeat_q && early_skip;
	assign sts.out_free = out_free;
	assign sts.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			repeat_q <= 1'b0;
			iv_q     <= frd_pkg::IV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frd_pkg::REG_RUN:      run_q    <= cfg_wdata[0];
				frd_pkg::REG_REPEAT:   repeat_q <= cfg_wdata[0];
				frd_pkg::REG_INTERVAL: iv_q     <= cfg_wdata[IV_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			prev_q     <= '0;
			has_rate_q <= 1'b0;
			n_q        <= '0;
		end else if (run_toggle) begin
			slot_q <= '0;
			prev_q <= '0;
		end else if (cmd.cap) begin
			n_q <= '0;
			if (run_q) begin
				has_rate_q <= (prev_q != '0) && (in_ts64 != prev_q);
				prev_q     <= in_ts64;
				if (slot_q == '0) begin
					slot_q <= in_ts64;
				end
			end else begin
				has_rate_q <= 1'b0;
				prev_q     <= '0;
				slot_q     <= '0;
			end
		end else if (cmd.emit) begin
			if (cmd.act == frd_pkg::ACT_REPEAT) begin
				n_q    <= n_q + CNT_W'(1);
				slot_q <= slot_adv;
			end else if (cmd.act == frd_pkg::ACT_FWD) begin
				slot_q <= slot_adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			tag_q <= in_tag;
			ts_q  <= in_ts;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_tag    <= tag_q;
			out_ts     <= ts_q;
			out_action <= cmd.act;
			out_last   <= cmd.act != frd_pkg::ACT_REPEAT;
		end
	end

	assign out_valid = ov_q;

endmodule

// ===== hdl/frd_ctrl.sv =====
module frd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  frd_pkg::sts_t sts,
	output logic          in_ready,
	output frd_pkg::cmd_t cmd
);

	frd_pkg::state_t state_q;
	frd_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frd_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			frd_pkg::S_IDLE: begin
				if (in_valid && !sts.div_busy) begin
					state_nxt = frd_pkg::S_DEC;
				end
			end
			frd_pkg::S_DEC: begin
				if (sts.out_free && !(sts.run && sts.rep_go)) begin
					state_nxt = frd_pkg::S_IDLE;
				end
			end
			default: state_nxt = frd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '{cap: 1'b0, emit: 1'b0, act: frd_pkg::ACT_FWD};
		unique case (state_q)
			frd_pkg::S_IDLE: begin
				in_ready = !sts.div_busy;
				cmd.cap  = in_valid && !sts.div_busy;
			end
			frd_pkg::S_DEC: begin
				cmd.emit = sts.out_free;
				priority if (!sts.run) begin
					cmd.act = frd_pkg::ACT_STOP;
				end else if (sts.rep_go) begin
					cmd.act = frd_pkg::ACT_REPEAT;
				end else if (sts.skip_go) begin
					cmd.act = frd_pkg::ACT_SKIP;
				end else begin
					cmd.act = frd_pkg::ACT_FWD;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/frame_rate_drop_repeat_top.sv =====
// channel   dir  payload                             handshake
// in_ch     in   frame_tag[31:0], frame_timestamp    valid / ready
// out_ch    out  out_tag, out_timestamp, action, last valid / ready
// cfg       in   cfg_index[1:0], cfg_wdata[31:0]     cfg_we, no stall
//
// an item is accepted, then decided; the decide step emits each repeated copy and
// the final result into the output register, one per cycle while out_ch is free
// a write of output_interval_ns starts a shift and reciprocal multiply for the snap
// window; in_ch.ready stays low while the divider is busy after the write
// arst_n clears config to its defaults and the slot and previous-frame state
// a stalled out_ch holds the decide step; the next item is taken while the
// final result of the previous one waits
module frame_rate_drop_repeat_top #(
	parameter int unsigned MAX_REPEATS = frd_pkg::MAX_REPEATS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [frd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	frd_in_if.sink                         in_ch,
	frd_out_if.source                      out_ch
);

	frd_pkg::cmd_t cmd;
	frd_pkg::sts_t sts;
	logic          in_ready;

	frd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	frd_dp #(
		.MAX_REPEATS (MAX_REPEATS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_tag     (in_ch.frame_tag),
		.in_ts      (in_ch.frame_timestamp),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_tag    (out_ch.out_tag),
		.out_ts     (out_ch.out_timestamp),
		.out_action (out_ch.action),
		.out_last   (out_ch.last)
	);

	assign in_ch.ready = in_ready;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second item accepted while one is being decided");

	a_repeat_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.action == frd_pkg::ACT_REPEAT) |-> !out_ch.last)
		else $error("repeated copy marked last");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.action == frd_pkg::ACT_STOP ||
		out_ch.action == frd_pkg::ACT_SKIP || out_ch.action == frd_pkg::ACT_FWD))
		|-> out_ch.last)
		else $error("final result not marked last");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !in_ch.ready)
		else $error("item accepted while snap window is being computed");

endmodule
